@@ rtl/stip_pkg.sv @@
package stip_pkg;

  // parse phases
  typedef enum logic [2:0] {
    PH_SPACE,
    PH_PRE,
    PH_DIGITS,
    PH_XSEEN,
    PH_DONE
  } phase_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DIGITS = 2'd1,
    ST_RANGE     = 2'd2,
    ST_BAD_BASE  = 2'd3
  } status_t;

  // configuration register indexes
  localparam logic CFG_NUMBER_BASE   = 1'b0;
  localparam logic CFG_SIGNED_RESULT = 1'b1;

  localparam int unsigned BASE_BITS  = 6;
  localparam int unsigned CFG_BITS   = 6;
  localparam logic [BASE_BITS-1:0] BASE_LIMIT   = 6'd36;
  localparam logic [BASE_BITS-1:0] BASE_OCTAL   = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DECIMAL = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX     = 6'd16;
  localparam logic [BASE_BITS-1:0] BASE_AUTO    = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_ONE     = 6'd1;
  localparam logic [BASE_BITS-1:0] BASE_RESET   = 6'd10;

  // character codes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;

  // digit value marking a byte that is no digit at all
  localparam logic [BASE_BITS-1:0] DIGIT_NONE = 6'd63;

  // digit value of a byte, letters in either case
  function automatic logic [BASE_BITS-1:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = {2'b00, DIGIT_NONE};
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d = c - CH_LOWER_A + 8'd10;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d = c - CH_UPPER_A + 8'd10;
    end
    return d[BASE_BITS-1:0];
  endfunction

  function automatic logic base_bad(input logic [BASE_BITS-1:0] b);
    return (b == BASE_ONE) || (b > BASE_LIMIT);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

@@ rtl/stip_if.sv @@
// byte stream into the parser
interface stip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

// parse results out of the parser
interface stip_out_if #(
  parameter int WORD_BITS   = 32,
  parameter int OFFSET_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [WORD_BITS-1:0]   value;
  logic [OFFSET_BITS-1:0] end_offset;
  logic [1:0]             status;

  modport source (output valid, output value, output end_offset, output status,
                  input ready);
  modport sink (input valid, input value, input end_offset, input status,
                output ready);
endinterface

@@ rtl/string_to_integer_parser.sv @@
// String to integer parser, strtol / strtoul style.
// in_ch carries one byte of the string per word, with last marking the
// final byte; a string gives exactly one word on out_ch (value, end_offset,
// status), taken when its last byte has been parsed.
// The configuration port writes number_base (index 0, 2..36, 0 = auto
// detect) and signed_result (index 1); write only while no string is open.
// Throughput: one byte per cycle while no last byte waits. A byte is
// registered when it is accepted and parsed from the input register against
// the running state, where a single multiply-add by the radix updates the
// accumulator; the output register is loaded when a last byte is parsed.
// When out_ch stalls with a result held, bytes that close no string still
// flow; a last byte waits in the input register until the result is taken,
// and in_ch.ready drops behind it.
// Reset (rst_n low, synchronous) empties both registers, clears the parse
// state and sets number_base to 10 and signed_result to 1.
module string_to_integer_parser #(
  parameter int WORD_BITS   = 32,
  parameter int OFFSET_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  stip_in_if.sink                     in_ch,
  stip_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [stip_pkg::CFG_BITS-1:0] cfg_data
);
  import stip_pkg::*;

  localparam int MUL_BITS = WORD_BITS + BASE_BITS;
  localparam logic [WORD_BITS-1:0] WORD_ONES = {WORD_BITS{1'b1}};
  localparam logic [WORD_BITS-1:0] SIGNED_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] SIGNED_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // configuration registers
  logic [BASE_BITS-1:0] cfg_base_r;
  logic                 cfg_signed_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;

  // parse state
  phase_t                 phase_r, phase_nxt;
  logic                   neg_r, neg_nxt;
  logic [BASE_BITS-1:0]   base_r, base_nxt;
  logic [WORD_BITS-1:0]   acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   zp_r, zp_nxt;
  logic                   seen_r, seen_nxt;
  logic [OFFSET_BITS-1:0] pos_r, next_pos;
  logic [OFFSET_BITS-1:0] dend_r, dend_nxt;

  // result register
  logic                   out_valid_r;
  logic [WORD_BITS-1:0]   out_value_r, out_value_nxt;
  logic [OFFSET_BITS-1:0] out_end_r, out_end_nxt;
  status_t                out_status_r, out_status_nxt;

  logic                 proc_go;
  logic                 held;
  logic                 dig_step;
  logic                 x_taken;
  logic                 take;
  logic [BASE_BITS-1:0] digit;
  logic [MUL_BITS-1:0]  mul;
  logic [MUL_BITS:0]    mac;
  logic                 mac_ovf;
  logic [BASE_BITS-1:0] res_base;

  // handshake: a last byte needs room in the result register
  assign proc_go     = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || proc_go;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = out_value_r;
  assign out_ch.end_offset = out_end_r;
  assign out_ch.status     = out_status_r;

  assign digit    = digit_of(s1_char_r);
  assign next_pos = (pos_r == {OFFSET_BITS{1'b1}}) ? pos_r : pos_r + 1'b1;

  // phase control for one byte
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    base_nxt  = base_r;
    zp_nxt    = zp_r;
    held      = 1'b0;
    dig_step  = 1'b0;
    x_taken   = 1'b0;
    take      = 1'b0;

    // whitespace skip, base latch and sign
    if (phase_r == PH_SPACE) begin
      if (is_space(s1_char_r)) begin
        held = 1'b1;
      end else begin
        base_nxt  = cfg_base_r;
        phase_nxt = PH_PRE;
        if (s1_char_r == CH_PLUS || s1_char_r == CH_MINUS) begin
          neg_nxt = (s1_char_r == CH_MINUS);
          held    = 1'b1;
        end
      end
    end

    if (!held) begin
      unique case (phase_nxt)
        PH_PRE: begin
          if (base_bad(base_nxt)) begin
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_DIGITS;
            if (s1_char_r == CH_ZERO) begin
              zp_nxt = 1'b1;
            end else begin
              if (base_nxt == BASE_AUTO) base_nxt = BASE_DECIMAL;
              dig_step = 1'b1;
            end
          end
        end
        PH_DIGITS: dig_step = 1'b1;
        PH_XSEEN: begin
          if (digit < BASE_HEX) begin
            take      = 1'b1;
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        default: ;
      endcase

      // digit after a possible leading zero
      if (dig_step) begin
        if (zp_nxt) begin
          zp_nxt = 1'b0;
          if ((s1_char_r == CH_LOWER_X || s1_char_r == CH_UPPER_X) &&
              (base_nxt == BASE_AUTO || base_nxt == BASE_HEX)) begin
            base_nxt  = BASE_HEX;
            phase_nxt = PH_XSEEN;
            x_taken   = 1'b1;
          end else if (base_nxt == BASE_AUTO) begin
            base_nxt = BASE_OCTAL;
          end
        end
        if (!x_taken) begin
          if (digit < base_nxt) take = 1'b1;
          else phase_nxt = PH_DONE;
        end
      end
    end
  end

  // multiply-add by the radix, overflow when the sum leaves the word
  assign mul     = {{BASE_BITS{1'b0}}, acc_r} * {{WORD_BITS{1'b0}}, base_nxt};
  assign mac     = {1'b0, mul} + {{(MUL_BITS+1-BASE_BITS){1'b0}}, digit};
  assign mac_ovf = (mac[MUL_BITS:WORD_BITS] != '0);

  // accumulator and digit bookkeeping
  always_comb begin
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    seen_nxt = seen_r;
    dend_nxt = dend_r;
    if (take) begin
      seen_nxt = 1'b1;
      dend_nxt = next_pos;
      if (!ovf_r) begin
        if (mac_ovf) ovf_nxt = 1'b1;
        else acc_nxt = mac[WORD_BITS-1:0];
      end
    end else if (zp_nxt && !zp_r) begin
      // leading zero counts as the digits until told otherwise
      seen_nxt = 1'b1;
      dend_nxt = next_pos;
    end
  end

  // result for a closing byte
  assign res_base = (phase_nxt == PH_SPACE) ? cfg_base_r : base_nxt;

  always_comb begin
    out_value_nxt  = '0;
    out_end_nxt    = '0;
    out_status_nxt = ST_OK;
    priority if (base_bad(res_base)) begin
      out_status_nxt = ST_BAD_BASE;
    end else if (!seen_nxt) begin
      out_status_nxt = ST_NO_DIGITS;
    end else begin
      out_end_nxt = dend_nxt;
      if (cfg_signed_r) begin
        if (neg_nxt) begin
          if (ovf_nxt || acc_nxt > SIGNED_MIN) begin
            out_value_nxt  = SIGNED_MIN;
            out_status_nxt = ST_RANGE;
          end else begin
            out_value_nxt = '0 - acc_nxt;
          end
        end else begin
          if (ovf_nxt || acc_nxt > SIGNED_MAX) begin
            out_value_nxt  = SIGNED_MAX;
            out_status_nxt = ST_RANGE;
          end else begin
            out_value_nxt = acc_nxt;
          end
        end
      end else begin
        if (ovf_nxt) begin
          out_value_nxt  = WORD_ONES;
          out_status_nxt = ST_RANGE;
        end else begin
          out_value_nxt = neg_nxt ? ('0 - acc_nxt) : acc_nxt;
        end
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r   <= BASE_RESET;
      cfg_signed_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUMBER_BASE:   cfg_base_r   <= cfg_data[BASE_BITS-1:0];
        CFG_SIGNED_RESULT: cfg_signed_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_char_r <= in_ch.character;
      s1_last_r <= in_ch.last;
    end
  end

  // parse state, cleared after each string
  always_ff @(posedge clk) begin
    if (!rst_n || (proc_go && s1_last_r)) begin
      phase_r <= PH_SPACE;
      neg_r   <= 1'b0;
      base_r  <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      zp_r    <= 1'b0;
      seen_r  <= 1'b0;
      pos_r   <= '0;
      dend_r  <= '0;
    end else if (proc_go) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      base_r  <= base_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      zp_r    <= zp_nxt;
      seen_r  <= seen_nxt;
      pos_r   <= next_pos;
      dend_r  <= dend_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && s1_last_r) begin
      out_value_r  <= out_value_nxt;
      out_end_r    <= out_end_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  // a new result only comes from a closing byte
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_last_r))
    else $error("result loaded without a closing byte");

  // parse state is clean after a string closes
  assert property (@(posedge clk) disable iff (!rst_n)
    (proc_go && s1_last_r) |=> (phase_r == PH_SPACE && pos_r == '0 && !ovf_r))
    else $error("parse state not cleared after result");

  // a converted result always points past at least one byte
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_OK) |-> (out_end_r != '0))
    else $error("converted result with zero end offset");

  // no-digit and bad-base results carry zero value and offset
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_NO_DIGITS || out_status_r == ST_BAD_BASE))
      |-> (out_value_r == '0 && out_end_r == '0))
    else $error("empty result with nonzero payload");

  // pending leading zero only while digits are being read
  assert property (@(posedge clk) disable iff (!rst_n)
    zp_r |-> (phase_r == PH_DIGITS && seen_r))
    else $error("leading zero pending outside digit phase");

endmodule
